### sv/rwsp_pkg.sv
// Shared types, constants and helpers of the register write sequence player.
package rwsp_pkg;

   // Table size; the table depth is a power of two.
   localparam int TABLE_AW    = 12;
   localparam int TABLE_DEPTH = 1 << TABLE_AW;
   localparam int IDX_W       = 12;
   localparam int WORD_W      = 16;
   localparam int DELAY_W     = 8;
   localparam int FRAME_W     = 4;
   localparam int REG_ADDR_W  = 6;
   localparam int REG_DATA_W  = 8;

   // Longest run of chained writes on one tick.
   localparam int MAX_CHAIN   = 63;
   localparam int WRITES_W    = $clog2(MAX_CHAIN + 1);

   // Configuration port.
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;
   localparam logic REG_LOOP_END   = 1'b0;
   localparam logic REG_LOOP_START = 1'b1;

   // Input opcodes and result kinds.
   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_TICK    = 1'b1;
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_END   = 1'b1;

   // Command word types held in the top two bits of a word.
   typedef enum logic [1:0] {
      WT_WRITE_WAIT1 = 2'd0,
      WT_WRITE_WAIT2 = 2'd1,
      WT_WAIT        = 2'd2,
      WT_CHAIN       = 2'd3
   } word_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_EVAL = 4'b0100,
      ST_END  = 4'b1000
   } state_type;

   typedef struct packed {
      logic [IDX_W-1:0] loop_end;
      logic [IDX_W-1:0] loop_start;
   } loop_cfg_type;

   localparam int EXT_W = (TABLE_AW > IDX_W) ? TABLE_AW : IDX_W;

   // Maps a 12-bit index onto a table entry (index modulo the table depth).
   function automatic logic [TABLE_AW-1:0] table_addr(input logic [IDX_W-1:0] idx);
      logic [EXT_W-1:0] ext;
      ext = EXT_W'(idx);
      return ext[TABLE_AW-1:0];
   endfunction

endpackage

### sv/rwsp_ram.sv
// Generic single-port RAM with a registered read.
module rwsp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic                     we,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### sv/rwsp_csr.sv
// Configuration registers of the sequence player behind an APB-style port.
module rwsp_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [rwsp_pkg::CSR_AW-1:0]    paddr,
   input  logic [rwsp_pkg::CSR_DW-1:0]    pwdata,
   output logic [rwsp_pkg::CSR_DW-1:0]    prdata,
   output logic                           pready,
   output rwsp_pkg::loop_cfg_type         loop_cfg
);

   logic [rwsp_pkg::IDX_W-1:0] loop_end_ff;
   logic [rwsp_pkg::IDX_W-1:0] loop_end_in;
   logic [rwsp_pkg::IDX_W-1:0] loop_start_ff;
   logic [rwsp_pkg::IDX_W-1:0] loop_start_in;
   logic                       wr_en;
   logic                       reg_sel;

   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[2];

   always_comb begin
      loop_end_in   = loop_end_ff;
      loop_start_in = loop_start_ff;
      if (wr_en) begin
         case (reg_sel)
            rwsp_pkg::REG_LOOP_END:   loop_end_in   = pwdata[rwsp_pkg::IDX_W-1:0];
            rwsp_pkg::REG_LOOP_START: loop_start_in = pwdata[rwsp_pkg::IDX_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loop_end_ff   <= '0;
         loop_start_ff <= '0;
      end else begin
         loop_end_ff   <= loop_end_in;
         loop_start_ff <= loop_start_in;
      end
   end

   always_comb begin
      case (reg_sel)
         rwsp_pkg::REG_LOOP_END:
            prdata = {{(rwsp_pkg::CSR_DW - rwsp_pkg::IDX_W){1'b0}}, loop_end_ff};
         rwsp_pkg::REG_LOOP_START:
            prdata = {{(rwsp_pkg::CSR_DW - rwsp_pkg::IDX_W){1'b0}}, loop_start_ff};
         default:
            prdata = '0;
      endcase
   end

   assign pready              = 1'b1;
   assign loop_cfg.loop_end   = loop_end_ff;
   assign loop_cfg.loop_start = loop_start_ff;

endmodule

### sv/register_write_sequence_player.sv
// Top level: plays back a table of sound-chip command words, one step per tick.
// A load item is written to the table in the cycle it is accepted; the next item is taken at once.
// A tick with a pending delay goes straight to the end state and gives its end-of-tick item from there.
// A tick reads its table words one at a time on the one table port: each word passes a table read
// state and a decode state, and the end-of-tick item follows from the end state.
// Reset clears the control state and the loop registers; the table is not cleared.
module register_write_sequence_player (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_opcode,
   input  logic [rwsp_pkg::IDX_W-1:0]         req_load_address,
   input  logic [rwsp_pkg::WORD_W-1:0]        req_load_word,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_kind,
   output logic [rwsp_pkg::REG_ADDR_W-1:0]    rsp_reg_address,
   output logic [rwsp_pkg::REG_DATA_W-1:0]    rsp_reg_data,
   output logic [rwsp_pkg::FRAME_W-1:0]       rsp_frame_count,
   output logic                               rsp_chain_overrun,
   output logic                               rsp_last,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [rwsp_pkg::CSR_AW-1:0]        paddr,
   input  logic [rwsp_pkg::CSR_DW-1:0]        pwdata,
   output logic [rwsp_pkg::CSR_DW-1:0]        prdata,
   output logic                               pready
);

   rwsp_pkg::loop_cfg_type loop_cfg;

   rwsp_pkg::state_type                 state_ff, state_in;
   logic [rwsp_pkg::IDX_W-1:0]          read_index_ff, read_index_in;
   logic [rwsp_pkg::DELAY_W-1:0]        delay_ff, delay_in;
   logic [rwsp_pkg::FRAME_W-1:0]        frames_ff, frames_in;
   logic                                pending_ff, pending_in;
   logic [rwsp_pkg::WRITES_W-1:0]       writes_ff, writes_in;
   logic                                cut_ff, cut_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_kind_ff, rsp_kind_in;
   logic [rwsp_pkg::REG_ADDR_W-1:0]     rsp_reg_address_ff, rsp_reg_address_in;
   logic [rwsp_pkg::REG_DATA_W-1:0]     rsp_reg_data_ff, rsp_reg_data_in;
   logic [rwsp_pkg::FRAME_W-1:0]        rsp_frame_count_ff, rsp_frame_count_in;
   logic                                rsp_chain_overrun_ff, rsp_chain_overrun_in;
   logic                                rsp_last_ff, rsp_last_in;

   logic                                req_accept;
   logic                                out_free;
   logic                                ram_we;
   logic                                ram_re;
   logic [rwsp_pkg::TABLE_AW-1:0]       ram_addr;
   logic [rwsp_pkg::WORD_W-1:0]         ram_rdata;
   rwsp_pkg::word_kind_type             word_kind;
   logic                                chain_full;

   rwsp_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .loop_cfg (loop_cfg)
   );

   assign req_stall  = (state_ff != rwsp_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign ram_we   = req_accept && (req_opcode == rwsp_pkg::OP_LOAD);
   assign ram_re   = (state_ff == rwsp_pkg::ST_READ);
   assign ram_addr = ram_re ? rwsp_pkg::table_addr(read_index_ff)
                            : rwsp_pkg::table_addr(req_load_address);

   rwsp_ram #(
      .WIDTH (rwsp_pkg::WORD_W),
      .DEPTH (rwsp_pkg::TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .addr  (ram_addr),
      .we    (ram_we),
      .wdata (req_load_word),
      .re    (ram_re),
      .rdata (ram_rdata)
   );

   assign word_kind  = rwsp_pkg::word_kind_type'(ram_rdata[15:14]);
   // The write being decoded now would be the last one the chain may take.
   assign chain_full = (writes_ff >= rwsp_pkg::WRITES_W'(rwsp_pkg::MAX_CHAIN - 1));

   always_comb begin
      state_in             = state_ff;
      read_index_in        = read_index_ff;
      delay_in             = delay_ff;
      frames_in            = frames_ff;
      pending_in           = pending_ff;
      writes_in            = writes_ff;
      cut_in               = cut_ff;
      rsp_valid_in         = rsp_valid_ff && rsp_stall;
      rsp_kind_in          = rsp_kind_ff;
      rsp_reg_address_in   = rsp_reg_address_ff;
      rsp_reg_data_in      = rsp_reg_data_ff;
      rsp_frame_count_in   = rsp_frame_count_ff;
      rsp_chain_overrun_in = rsp_chain_overrun_ff;
      rsp_last_in          = rsp_last_ff;

      case (state_ff)
         rwsp_pkg::ST_IDLE: begin
            if (req_accept && (req_opcode == rwsp_pkg::OP_TICK)) begin
               cut_in    = 1'b0;
               writes_in = '0;
               if (delay_ff == '0) begin
                  // A tick that resumes a cut chain does not start a new frame.
                  if (!pending_ff) begin
                     frames_in = frames_ff + 1'b1;
                  end
                  pending_in = 1'b0;
                  state_in   = rwsp_pkg::ST_READ;
               end else begin
                  state_in = rwsp_pkg::ST_END;
               end
            end
         end

         rwsp_pkg::ST_READ: begin
            read_index_in = read_index_ff + 1'b1;
            state_in      = rwsp_pkg::ST_EVAL;
         end

         rwsp_pkg::ST_EVAL: begin
            if (word_kind == rwsp_pkg::WT_WAIT) begin
               delay_in = ram_rdata[7:0];
               state_in = rwsp_pkg::ST_END;
            end else if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_kind_in          = rwsp_pkg::KIND_WRITE;
               rsp_reg_address_in   = ram_rdata[13:8];
               rsp_reg_data_in      = ram_rdata[7:0];
               rsp_frame_count_in   = frames_ff;
               rsp_chain_overrun_in = 1'b0;
               rsp_last_in          = 1'b0;
               writes_in            = writes_ff + 1'b1;
               case (word_kind)
                  rwsp_pkg::WT_WRITE_WAIT1: begin
                     delay_in = rwsp_pkg::DELAY_W'(1);
                     state_in = rwsp_pkg::ST_END;
                  end
                  rwsp_pkg::WT_WRITE_WAIT2: begin
                     delay_in = rwsp_pkg::DELAY_W'(2);
                     state_in = rwsp_pkg::ST_END;
                  end
                  rwsp_pkg::WT_CHAIN: begin
                     if (chain_full) begin
                        cut_in     = 1'b1;
                        pending_in = 1'b1;
                        state_in   = rwsp_pkg::ST_END;
                     end else begin
                        state_in = rwsp_pkg::ST_READ;
                     end
                  end
                  default: state_in = rwsp_pkg::ST_END;
               endcase
            end
         end

         rwsp_pkg::ST_END: begin
            if (out_free) begin
               if (delay_ff != '0) begin
                  delay_in = delay_ff - 1'b1;
               end
               // The loop check is made once per tick, after all reads.
               if (read_index_ff == loop_cfg.loop_end) begin
                  read_index_in = loop_cfg.loop_start;
               end
               rsp_valid_in         = 1'b1;
               rsp_kind_in          = rwsp_pkg::KIND_END;
               rsp_reg_address_in   = '0;
               rsp_reg_data_in      = '0;
               rsp_frame_count_in   = frames_ff;
               rsp_chain_overrun_in = cut_ff;
               rsp_last_in          = 1'b1;
               state_in             = rwsp_pkg::ST_IDLE;
            end
         end

         default: state_in = rwsp_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rwsp_pkg::ST_IDLE;
         read_index_ff <= '0;
         delay_ff      <= '0;
         frames_ff     <= '0;
         pending_ff    <= 1'b0;
         writes_ff     <= '0;
         cut_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         read_index_ff <= read_index_in;
         delay_ff      <= delay_in;
         frames_ff     <= frames_in;
         pending_ff    <= pending_in;
         writes_ff     <= writes_in;
         cut_ff        <= cut_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff          <= rsp_kind_in;
      rsp_reg_address_ff   <= rsp_reg_address_in;
      rsp_reg_data_ff      <= rsp_reg_data_in;
      rsp_frame_count_ff   <= rsp_frame_count_in;
      rsp_chain_overrun_ff <= rsp_chain_overrun_in;
      rsp_last_ff          <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_reg_address   = rsp_reg_address_ff;
   assign rsp_reg_data      = rsp_reg_data_ff;
   assign rsp_frame_count   = rsp_frame_count_ff;
   assign rsp_chain_overrun = rsp_chain_overrun_ff;
   assign rsp_last          = rsp_last_ff;

   // A cut chain is made only of chained writes, so the delay stays at zero.
   a_pending_no_delay : assert property (@(posedge clock) disable iff (reset)
      (state_ff == rwsp_pkg::ST_IDLE && pending_ff) |-> (delay_ff == '0))
      else $error("chain pending with a nonzero delay");

   a_writes_bound : assert property (@(posedge clock) disable iff (reset)
      writes_ff <= rwsp_pkg::WRITES_W'(rwsp_pkg::MAX_CHAIN))
      else $error("write chain ran past its limit");

   a_overrun_on_end : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_chain_overrun_ff) |-> (rsp_kind_ff == rwsp_pkg::KIND_END))
      else $error("chain overrun flagged on a write item");

   a_end_to_idle : assert property (@(posedge clock) disable iff (reset)
      (state_ff == rwsp_pkg::ST_END && out_free) |=>
         (state_ff == rwsp_pkg::ST_IDLE && rsp_valid_ff && rsp_last_ff))
      else $error("end of tick did not close the tick");

endmodule
